### rtl/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned CODE_W = 16;
  // merge of up to 7 pending bits with a 16-bit code
  localparam int unsigned ACC_W  = CODE_W + BYTE_W - 1;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned PAD_W  = 3;
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_PAD   = 2'd2
  } kind_e;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [1:0]        byte_kind;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  // one queued operation between front and back
  typedef struct packed {
    op_e               op;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } q_entry_t;

endpackage

`default_nettype wire

### rtl/huffman_code_bit_packer_unit.sv
// Top level of the Huffman code bit packer: front end, queue and back end.
//
//  channel | direction | word       | handshake
//  --------+-----------+------------+-------------------------
//  in      | input     | in_word_i  | in_valid_i / in_stall_o
//  out     | output    | out_word_o | out_valid_o / out_stall_i
//
// The front end takes one word per cycle while the two-entry queue has room;
// the table read is registered, and a word then passes the queue and the output register.
// The back end emits one byte per cycle while the output is not stalled; a symbol with a
// two-byte result or a flush with pending bits pops no new word until its second byte is out.
// Reset clears the control state and pending bits; the code table has no reset.
// A stall on the output fills the queue and then stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer_unit #(
  parameter int unsigned SYMBOL_COUNT  = 256,
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire hcbp_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output hcbp_pkg::out_word_t      out_word_o
);

  logic               q_push, q_full, q_pop, q_empty;
  hcbp_pkg::q_entry_t q_push_entry, q_head;

  hcbp_front #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_push_o   (q_push),
    .q_entry_o  (q_push_entry),
    .q_full_i   (q_full)
  );

  hcbp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  hcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

### rtl/hcbp_front.sv
// Front end: accepts commands, holds the code table, queues encode and flush work.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_front #(
  parameter int unsigned SYMBOL_COUNT  = 256,
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hcbp_pkg::in_word_t in_word_i,
  output logic                    q_push_o,
  output hcbp_pkg::q_entry_t      q_entry_o,
  input  wire logic               q_full_i
);

  localparam int unsigned IdxW   = $clog2(SYMBOL_COUNT);
  localparam int unsigned LenCap = (MAX_CODE_BITS < hcbp_pkg::CODE_W) ?
                                   MAX_CODE_BITS : hcbp_pkg::CODE_W;

  hcbp_pkg::tbl_entry_t code_mem_q [SYMBOL_COUNT];
  hcbp_pkg::tbl_entry_t rd_q;
  hcbp_pkg::tbl_entry_t wr_entry;

  logic                          s1_valid_q, s1_valid_d;
  hcbp_pkg::op_e                 s1_op_q, s1_op_d;
  logic                          accept, in_range, is_load, is_enc, is_flush;
  logic                          s1_drop, s1_go;
  logic [IdxW-1:0]               idx;
  logic [hcbp_pkg::LEN_W-1:0]    len_sat;
  logic [hcbp_pkg::CODE_W-1:0]   mask;

  assign idx      = in_word_i.symbol[IdxW-1:0];
  assign in_range = ({1'b0, in_word_i.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT));
  assign is_load  = (in_word_i.cmd == hcbp_pkg::CMD_LOAD)   && in_range;
  assign is_enc   = (in_word_i.cmd == hcbp_pkg::CMD_ENCODE) && in_range;
  assign is_flush = (in_word_i.cmd == hcbp_pkg::CMD_FLUSH);

  // zero-length codes produce nothing and never reach the queue
  assign s1_drop    = (s1_op_q == hcbp_pkg::OP_ENCODE) && (rd_q.len == '0);
  assign s1_go      = s1_valid_q && (s1_drop || !q_full_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    len_sat = (in_word_i.code_length > hcbp_pkg::LEN_W'(LenCap)) ?
              hcbp_pkg::LEN_W'(LenCap) : in_word_i.code_length;
    for (int i = 0; i < hcbp_pkg::CODE_W; i++) begin
      mask[i] = (hcbp_pkg::LEN_W'(i) < len_sat);
    end
    wr_entry.len  = len_sat;
    wr_entry.code = in_word_i.code_bits & mask;
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_load) begin
      code_mem_q[idx] <= wr_entry;
    end
    if (accept) begin
      rd_q <= code_mem_q[idx];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q && !s1_go;
    s1_op_d    = s1_op_q;
    if (accept) begin
      s1_valid_d = is_enc || is_flush;
      s1_op_d    = is_flush ? hcbp_pkg::OP_FLUSH : hcbp_pkg::OP_ENCODE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_op_q    <= hcbp_pkg::OP_ENCODE;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_op_q    <= s1_op_d;
    end
  end

  assign q_push_o       = s1_valid_q && !s1_drop && !q_full_i;
  assign q_entry_o.op   = s1_op_q;
  assign q_entry_o.len  = rd_q.len;
  assign q_entry_o.code = rd_q.code;

endmodule

`default_nettype wire

### rtl/hcbp_fifo.sv
// Short queue of operations between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire hcbp_pkg::q_entry_t push_entry_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output hcbp_pkg::q_entry_t      head_o
);

  localparam int unsigned Depth = hcbp_pkg::Q_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  hcbp_pkg::q_entry_t slot_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/hcbp_back.sv
// Back end: merges codes in the accumulator; one byte per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire hcbp_pkg::q_entry_t q_head_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hcbp_pkg::out_word_t     out_word_o
);

  logic [hcbp_pkg::ACC_W-1:0] acc_q, acc_d, merged;
  logic [hcbp_pkg::CNT_W-1:0] cnt_q, cnt_d, total;
  logic                       pad_q, pad_d;
  logic [hcbp_pkg::PAD_W-1:0] pad_val_q, pad_val_d;
  logic                       out_valid_q, out_valid_d;
  hcbp_pkg::out_word_t        out_q, emit_word;
  logic                       out_free, emit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign merged   = (acc_q << q_head_i.len) | hcbp_pkg::ACC_W'(q_head_i.code);
  assign total    = cnt_q + q_head_i.len;

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    pad_d     = pad_q;
    pad_val_d = pad_val_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_word = '0;
    if (out_free) begin
      if (pad_q) begin
        emit                = 1'b1;
        emit_word.out_byte  = hcbp_pkg::BYTE_W'(pad_val_q);
        emit_word.byte_kind = hcbp_pkg::KIND_PAD;
        emit_word.last      = 1'b1;
        pad_d               = 1'b0;
      end else if (cnt_q >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)) begin
        // second byte of a long merge; at most 7 bits remain after it
        emit                = 1'b1;
        emit_word.out_byte  = hcbp_pkg::BYTE_W'(acc_q >> (cnt_q - 5'd8));
        emit_word.byte_kind = hcbp_pkg::KIND_DATA;
        emit_word.last      = 1'b1;
        cnt_d               = cnt_q - 5'd8;
      end else if (!q_empty_i) begin
        q_pop_o = 1'b1;
        case (q_head_i.op)
          hcbp_pkg::OP_ENCODE: begin
            acc_d = merged;
            if (total >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)) begin
              emit                = 1'b1;
              emit_word.out_byte  = hcbp_pkg::BYTE_W'(merged >> (total - 5'd8));
              emit_word.byte_kind = hcbp_pkg::KIND_DATA;
              emit_word.last      = (total < 5'd16);
              cnt_d               = total - 5'd8;
            end else begin
              cnt_d = total;
            end
          end
          hcbp_pkg::OP_FLUSH: begin
            emit  = 1'b1;
            cnt_d = '0;
            if (cnt_q != '0) begin
              emit_word.out_byte  = hcbp_pkg::BYTE_W'(acc_q << (5'd8 - cnt_q));
              emit_word.byte_kind = hcbp_pkg::KIND_FINAL;
              emit_word.last      = 1'b0;
              pad_d               = 1'b1;
              pad_val_d           = hcbp_pkg::PAD_W'(5'd8 - cnt_q);
            end else begin
              emit_word.out_byte  = '0;
              emit_word.byte_kind = hcbp_pkg::KIND_PAD;
              emit_word.last      = 1'b1;
            end
          end
          default: begin
            q_pop_o = 1'b1;
          end
        endcase
      end
    end
    out_valid_d = emit ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pad_q       <= pad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    pad_val_q <= pad_val_d;
    if (emit) begin
      out_q <= emit_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### rtl/hcbp_checker.sv
// Port-level checks of the bit packer and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire hcbp_pkg::in_word_t  in_word_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire hcbp_pkg::out_word_t out_word_o
);

  logic out_acc, kind_final, kind_pad;

  assign out_acc    = out_valid_o && !out_stall_i;
  assign kind_final = (out_word_o.byte_kind == hcbp_pkg::KIND_FINAL);
  assign kind_pad   = (out_word_o.byte_kind == hcbp_pkg::KIND_PAD);

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word changed under stall");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // a padded byte never ends a word's results; a pad count always does
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_final || kind_pad) |-> (out_word_o.last == kind_pad))
    else $error("last flag disagrees with byte kind");

  // the pad count follows the padded byte directly
  a_pad_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && kind_final |=> out_valid_o && kind_pad)
    else $error("pad count did not follow padded byte");

  // no output in the first cycles after reset
  a_idle_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o ##1 !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
